### design/gtg_pkg.sv
// Shared types, constants and tables of the go-to-goal steering block.
package gtg_pkg;

   // Default number of rotations in the bearing unit
   localparam int ANGLE_ITERATIONS_DEF = 16;

   // Entries in the arctangent table; rotations stop there
   localparam int ATAN_N = 24;

   // Fixed widths of the arithmetic
   localparam int DELTA_W = 25;   // axis error, Q8.16
   localparam int CRD_W   = 36;   // rotation unit x and y
   localparam int ANG_W   = 34;   // rotation unit angle, Q30
   localparam int ERR_W   = 21;   // bearing error, Q16
   localparam int TURN_W  = 30;   // unsaturated turn rate, Q16
   localparam int RAD_W   = 50;   // squared distance
   localparam int ROOT_W  = 25;   // distance
   localparam int QUO_W   = 26;   // speed quotient bits
   localparam int MUL_W   = 27;   // shared multiplier operand
   localparam int CNT_W   = 5;

   // Last step indexes of the iterative sections
   localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(ROOT_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W - 1);

   // Angle constants
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [ERR_W-1:0] PI_Q16      = 21'sd205887;
   localparam logic signed [ERR_W-1:0] TWO_PI_Q16  = 21'sd411775;

   // Register indexes
   localparam logic [1:0] REG_TURN_GAIN   = 2'd0;
   localparam logic [1:0] REG_SPEED_GAIN  = 2'd1;
   localparam logic [1:0] REG_MIN_DIVISOR = 2'd2;
   localparam logic [1:0] REG_TOLERANCE   = 2'd3;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_SQX, OP_SQY, OP_SUM, OP_ITER,
      OP_TURN, OP_SPD, OP_DIVI, OP_DIV, OP_OUT
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [CNT_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic [15:0] turn_gain;
      logic [15:0] speed_gain;
      logic [19:0] min_divisor;
      logic [15:0] tolerance;
   } cfg_type;

   // Arctangent of 2^-i in Q30
   function automatic logic signed [ANG_W-1:0] atan_entry(input logic [CNT_W-1:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:  v = 34'sd843314857;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043837;
         5'd3:  v = 34'sd133525159;
         5'd4:  v = 34'sd67021687;
         5'd5:  v = 34'sd33543516;
         5'd6:  v = 34'sd16775851;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194283;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048576;
         5'd11: v = 34'sd524288;
         5'd12: v = 34'sd262144;
         5'd13: v = 34'sd131072;
         5'd14: v = 34'sd65536;
         5'd15: v = 34'sd32768;
         5'd16: v = 34'sd16384;
         5'd17: v = 34'sd8192;
         5'd18: v = 34'sd4096;
         5'd19: v = 34'sd2048;
         5'd20: v = 34'sd1024;
         5'd21: v = 34'sd512;
         5'd22: v = 34'sd256;
         5'd23: v = 34'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### design/gtg_csr.sv
// Configuration registers with their bus port.
module gtg_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output gtg_pkg::cfg_type     cfg
);

   gtg_pkg::cfg_type cfg_ff, cfg_in;

   // Decode writes
   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            gtg_pkg::REG_TURN_GAIN:   cfg_in.turn_gain   = pwdata[15:0];
            gtg_pkg::REG_SPEED_GAIN:  cfg_in.speed_gain  = pwdata[15:0];
            gtg_pkg::REG_MIN_DIVISOR: cfg_in.min_divisor = pwdata[19:0];
            gtg_pkg::REG_TOLERANCE:   cfg_in.tolerance   = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.turn_gain   <= 16'd1280;
         cfg_ff.speed_gain  <= 16'd32768;
         cfg_ff.min_divisor <= 20'd32768;
         cfg_ff.tolerance   <= 16'd655;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (paddr[3:2])
         gtg_pkg::REG_TURN_GAIN:   prdata = {16'd0, cfg_ff.turn_gain};
         gtg_pkg::REG_SPEED_GAIN:  prdata = {16'd0, cfg_ff.speed_gain};
         gtg_pkg::REG_MIN_DIVISOR: prdata = {12'd0, cfg_ff.min_divisor};
         gtg_pkg::REG_TOLERANCE:   prdata = {16'd0, cfg_ff.tolerance};
         default:                  prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

### design/gtg_ctrl.sv
// Sequencer that steps the datapath through one word.
module gtg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output gtg_pkg::cmd_type     cmd
);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_SQX  = 10'b0000000010,
      ST_SQY  = 10'b0000000100,
      ST_SUM  = 10'b0000001000,
      ST_ITER = 10'b0000010000,
      ST_TURN = 10'b0000100000,
      ST_SPD  = 10'b0001000000,
      ST_DIVI = 10'b0010000000,
      ST_DIV  = 10'b0100000000,
      ST_OUT  = 10'b1000000000
   } state_type;

   state_type                    state_ff, state_in;
   logic [gtg_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                         valid_ff, valid_in;
   logic                         out_free;

   assign out_free = !valid_ff || !rsp_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff && rsp_stall;
      cmd.op   = gtg_pkg::OP_NONE;
      cmd.step = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = gtg_pkg::OP_LOAD;
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            cmd.op   = gtg_pkg::OP_SQX;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.op   = gtg_pkg::OP_SQY;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = gtg_pkg::OP_SUM;
            cnt_in   = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            cmd.op = gtg_pkg::OP_ITER;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == gtg_pkg::ITER_LAST) begin
               state_in = ST_TURN;
            end
         end
         ST_TURN: begin
            cmd.op   = gtg_pkg::OP_TURN;
            state_in = ST_SPD;
         end
         ST_SPD: begin
            cmd.op   = gtg_pkg::OP_SPD;
            state_in = ST_DIVI;
         end
         ST_DIVI: begin
            cmd.op   = gtg_pkg::OP_DIVI;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = gtg_pkg::OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == gtg_pkg::DIV_LAST) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.op   = gtg_pkg::OP_OUT;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

### design/gtg_dp.sv
// Datapath: shared multiplier, bearing rotations, square root and divider.
module gtg_dp #(
   parameter int ANGLE_ITERATIONS = gtg_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gtg_pkg::cmd_type     cmd,
   input  gtg_pkg::cfg_type     cfg,
   input  logic signed [23:0]   req_pos_x,
   input  logic signed [23:0]   req_pos_y,
   input  logic signed [18:0]   req_heading,
   input  logic signed [23:0]   req_target_x,
   input  logic signed [23:0]   req_target_y,
   input  logic                 req_restart,
   output logic signed [23:0]   rsp_turn_rate,
   output logic [25:0]          rsp_forward_speed,
   output logic [1:0]           rsp_arrival_stage
);

   localparam int DW = gtg_pkg::DELTA_W;
   localparam int CW = gtg_pkg::CRD_W;
   localparam int AW = gtg_pkg::ANG_W;
   localparam int EW = gtg_pkg::ERR_W;
   localparam int TW = gtg_pkg::TURN_W;
   localparam int RW = gtg_pkg::RAD_W;
   localparam int SW = gtg_pkg::ROOT_W;
   localparam int QW = gtg_pkg::QUO_W;
   localparam int MW = gtg_pkg::MUL_W;

   logic signed [DW-1:0]   dx_ff, dy_ff, dx_new, dy_new;
   logic signed [18:0]     hd_ff;
   logic [1:0]             stage_ff, stage_in, stage_base;
   logic [DW-1:0]          adx, ady;
   logic signed [MW-1:0]   ma, mb;
   logic signed [2*MW-1:0] prod_ff;
   logic [RW-1:0]          rad_ff;
   logic [SW+1:0]          rem_ff;
   logic [SW-1:0]          root_ff;
   logic [SW+3:0]          rem_sh, trial;
   logic signed [CW-1:0]   cx_ff, cy_ff, cx0, cy0, xs, ys;
   logic signed [AW-1:0]   cz_ff, cz0;
   logic                   zero_ff;
   logic signed [AW-1:0]   zr;
   logic signed [EW-1:0]   bear, err_raw, err;
   logic signed [TW-1:0]   turn_ff;
   logic signed [2*MW-1:0] tr;
   logic [TW-1:0]          mag, floor_div, div_sel;
   logic [TW-1:0]          div_ff, drem_ff;
   logic [TW:0]            dr2;
   logic [41:0]            dvd;
   logic [QW-1:0]          dvd_ff, quo_ff;
   logic                   sat_ff;
   logic signed [23:0]     turn_o_ff;
   logic [25:0]            speed_o_ff;
   logic [1:0]             stage_o_ff;

   // Axis errors and arrival check of the incoming word
   assign dx_new = DW'(req_target_x) - DW'(req_pos_x);
   assign dy_new = DW'(req_target_y) - DW'(req_pos_y);
   assign adx    = dx_new[DW-1] ? DW'(-dx_new) : dx_new;
   assign ady    = dy_new[DW-1] ? DW'(-dy_new) : dy_new;

   always_comb begin
      stage_base = req_restart ? 2'd0 : stage_ff;
      stage_in   = stage_ff;
      if (cmd.op == gtg_pkg::OP_LOAD) begin
         stage_in = stage_base;
         if (adx <= DW'(cfg.tolerance) && ady <= DW'(cfg.tolerance) &&
             stage_base != 2'd3) begin
            stage_in = stage_base + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 2'd0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   // Bearing error, rounded to Q16 and wrapped once
   assign zr      = zero_ff ? '0 : cz_ff;
   assign bear    = EW'((zr + AW'(8192)) >>> 14);
   assign err_raw = bear - EW'(hd_ff);
   always_comb begin
      if (err_raw < -gtg_pkg::PI_Q16) begin
         err = err_raw + gtg_pkg::TWO_PI_Q16;
      end else if (err_raw > gtg_pkg::PI_Q16) begin
         err = err_raw - gtg_pkg::TWO_PI_Q16;
      end else begin
         err = err_raw;
      end
   end

   // Multiplier operand select
   always_comb begin
      case (cmd.op)
         gtg_pkg::OP_SQX: begin
            ma = MW'(dx_ff);
            mb = MW'(dx_ff);
         end
         gtg_pkg::OP_SQY: begin
            ma = MW'(dy_ff);
            mb = MW'(dy_ff);
         end
         gtg_pkg::OP_TURN: begin
            ma = MW'({1'b0, cfg.turn_gain});
            mb = MW'(err);
         end
         gtg_pkg::OP_SPD: begin
            ma = MW'({1'b0, cfg.speed_gain});
            mb = MW'({1'b0, root_ff});
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   // Rotation start: fold the left half plane onto the right
   always_comb begin
      cx0 = CW'(dx_ff) <<< 8;
      cy0 = CW'(dy_ff) <<< 8;
      cz0 = '0;
      if (dx_ff[DW-1]) begin
         if (!dy_ff[DW-1]) begin
            cx0 = CW'(dy_ff) <<< 8;
            cy0 = -(CW'(dx_ff) <<< 8);
            cz0 = gtg_pkg::HALF_PI_Q30;
         end else begin
            cx0 = -(CW'(dy_ff) <<< 8);
            cy0 = CW'(dx_ff) <<< 8;
            cz0 = -gtg_pkg::HALF_PI_Q30;
         end
      end
   end

   assign xs = cx_ff >>> cmd.step;
   assign ys = cy_ff >>> cmd.step;

   // Square root step: two radicand bits a cycle
   assign rem_sh = {rem_ff, rad_ff[RW-1:RW-2]};
   assign trial  = {2'b00, root_ff, 2'b01};

   // Divisor: larger of the turn magnitude and the floor
   assign tr        = prod_ff + (2*MW)'(128);
   assign mag       = turn_ff[TW-1] ? TW'(-turn_ff) : TW'(turn_ff);
   assign floor_div = (cfg.min_divisor == '0) ? TW'(1) : TW'(cfg.min_divisor);
   assign div_sel   = (mag > floor_div) ? mag : floor_div;
   assign dvd       = 42'(prod_ff[40:0]) + 42'(div_sel >> 1);
   assign dr2       = {drem_ff, dvd_ff[QW-1]};

   always_ff @(posedge clock) begin
      prod_ff <= ma * mb;
      case (cmd.op)
         gtg_pkg::OP_LOAD: begin
            dx_ff <= dx_new;
            dy_ff <= dy_new;
            hd_ff <= req_heading;
         end
         gtg_pkg::OP_SQY: begin
            rad_ff <= RW'(prod_ff);
         end
         gtg_pkg::OP_SUM: begin
            rad_ff  <= rad_ff + RW'(prod_ff);
            rem_ff  <= '0;
            root_ff <= '0;
            cx_ff   <= cx0;
            cy_ff   <= cy0;
            cz_ff   <= cz0;
            zero_ff <= (dx_ff == '0) && (dy_ff == '0);
         end
         gtg_pkg::OP_ITER: begin
            // Advance the square root
            rad_ff <= rad_ff << 2;
            if (rem_sh >= trial) begin
               rem_ff  <= (SW+2)'(rem_sh - trial);
               root_ff <= {root_ff[SW-2:0], 1'b1};
            end else begin
               rem_ff  <= (SW+2)'(rem_sh);
               root_ff <= {root_ff[SW-2:0], 1'b0};
            end
            // Advance the bearing rotation, no further than the table reaches
            if (32'(cmd.step) < ANGLE_ITERATIONS && 32'(cmd.step) < gtg_pkg::ATAN_N) begin
               if (cy_ff > 0) begin
                  cx_ff <= cx_ff + ys;
                  cy_ff <= cy_ff - xs;
                  cz_ff <= cz_ff + gtg_pkg::atan_entry(cmd.step);
               end else begin
                  cx_ff <= cx_ff - ys;
                  cy_ff <= cy_ff + xs;
                  cz_ff <= cz_ff - gtg_pkg::atan_entry(cmd.step);
               end
            end
         end
         gtg_pkg::OP_SPD: begin
            turn_ff <= tr[TW+7:8];
         end
         gtg_pkg::OP_DIVI: begin
            div_ff  <= div_sel;
            sat_ff  <= TW'(dvd[41:QW]) >= div_sel;
            drem_ff <= TW'(dvd[41:QW]);
            dvd_ff  <= dvd[QW-1:0];
         end
         gtg_pkg::OP_DIV: begin
            dvd_ff <= dvd_ff << 1;
            if (dr2 >= {1'b0, div_ff}) begin
               drem_ff <= TW'(dr2 - {1'b0, div_ff});
               quo_ff  <= {quo_ff[QW-2:0], 1'b1};
            end else begin
               drem_ff <= TW'(dr2);
               quo_ff  <= {quo_ff[QW-2:0], 1'b0};
            end
         end
         gtg_pkg::OP_OUT: begin
            if (turn_ff > TW'(24'sh7FFFFF)) begin
               turn_o_ff <= 24'sh7FFFFF;
            end else if (turn_ff < -TW'(25'sh800000)) begin
               turn_o_ff <= 24'sh800000;
            end else begin
               turn_o_ff <= turn_ff[23:0];
            end
            speed_o_ff <= sat_ff ? '1 : quo_ff;
            stage_o_ff <= stage_ff;
         end
         default: ;
      endcase
   end

   assign rsp_turn_rate     = turn_o_ff;
   assign rsp_forward_speed = speed_o_ff;
   assign rsp_arrival_stage = stage_o_ff;

endmodule

### design/go_to_goal_steering_top.sv
// Top level of the go-to-goal steering block.
//
//   channel   direction  handshake           payload
//   req       in         req_valid/req_stall pose, target, restart
//   rsp       out        rsp_valid/rsp_stall turn rate, forward speed, stage
//   csr       in/out     psel/penable/pready four setup registers
//
// A word passes through the load, the squares and their sum, the shared square
// root and rotation loop, the turn and speed products, the divider setup and the
// restoring divider before its result; the next word is taken only once idle.
// Reset is synchronous and returns the registers to their defaults and the
// arrival stage to zero. A waiting result holds the block before its last
// step; the next word may be taken while that result still waits.
module go_to_goal_steering_top #(
   parameter int ANGLE_ITERATIONS = gtg_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [23:0]   req_pos_x,
   input  logic signed [23:0]   req_pos_y,
   input  logic signed [18:0]   req_heading,
   input  logic signed [23:0]   req_target_x,
   input  logic signed [23:0]   req_target_y,
   input  logic                 req_restart,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [23:0]   rsp_turn_rate,
   output logic [25:0]          rsp_forward_speed,
   output logic [1:0]           rsp_arrival_stage,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   gtg_pkg::cfg_type cfg;
   gtg_pkg::cmd_type cmd;

   gtg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gtg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   gtg_dp #(
      .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_heading       (req_heading),
      .req_target_x      (req_target_x),
      .req_target_y      (req_target_y),
      .req_restart       (req_restart),
      .rsp_turn_rate     (rsp_turn_rate),
      .rsp_forward_speed (rsp_forward_speed),
      .rsp_arrival_stage (rsp_arrival_stage)
   );

endmodule
